// ----- design/mandelbrot_escape_time_top_macros.svh -----
// Assertion macros for the escape-time block checker.
// No dependencies; included by the checker file.
`ifndef MANDELBROT_ESCAPE_TIME_TOP_MACROS_SVH
`define MANDELBROT_ESCAPE_TIME_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is low
`define MBE_ASSERT_NOW(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("mbe check failed");

// Next-cycle implication, disabled while reset is low
`define MBE_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("mbe check failed");

`endif

// ----- design/mbe_pkg.sv -----
// Shared types, constants and saturating helpers for the escape-time block.
// No dependencies; used by every other design file except the macro header.
package mbe_pkg;

  // Field and port widths
  localparam int DATA_W     = 64;
  localparam int CFG_DATA_W = 64;
  localparam int PADDR_W    = 6;
  localparam int COORD_W    = 12;
  localparam int COUNT_W    = 16;
  localparam int DIM_REG_W  = 13;
  localparam int STEP_W     = 63;

  // Parameter defaults
  localparam int MAX_DIM_DEF      = 4096;
  localparam int PERIOD_CHECK_DEF = 23;

  // Q12.52 constants
  localparam logic [DATA_W-1:0] SMAX       = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [DATA_W-1:0] SMIN       = 64'h8000_0000_0000_0000;
  localparam logic [DATA_W-1:0] QONE       = 64'd1 << 52;
  localparam logic [DATA_W-1:0] QQUARTER   = 64'd1 << 50;
  localparam logic [DATA_W-1:0] QSIXTEENTH = 64'd1 << 48;
  localparam logic [DATA_W-1:0] QESCAPE    = 64'd400 << 52;

  // Register reset values
  localparam logic [STEP_W-1:0]    RST_PIXEL_STEP = 63'd1 << 52;
  localparam logic [COUNT_W-1:0]   RST_MAX_ITER   = 16'd256;
  localparam logic [DIM_REG_W-1:0] RST_IMAGE_DIM  = 13'd1024;

  // Register index (byte address / 8)
  typedef enum logic [2:0] {
    REG_CENTER_RE    = 3'd0,
    REG_CENTER_IM    = 3'd1,
    REG_PIXEL_STEP   = 3'd2,
    REG_MAX_ITER     = 3'd3,
    REG_IMAGE_WIDTH  = 3'd4,
    REG_IMAGE_HEIGHT = 3'd5
  } mbe_reg_t;

  // Configuration register file contents
  typedef struct packed {
    logic [DATA_W-1:0]    center_re;
    logic [DATA_W-1:0]    center_im;
    logic [STEP_W-1:0]    pixel_step;
    logic [COUNT_W-1:0]   max_iter;
    logic [DIM_REG_W-1:0] image_width;
    logic [DIM_REG_W-1:0] image_height;
  } mbe_cfg_t;

  // Product shift select
  typedef enum logic [1:0] {
    SH_0,
    SH_51,
    SH_52
  } mbe_sh_t;

  // Datapath operation
  typedef enum logic [3:0] {
    OP_NONE,
    OP_MAP_RE,
    OP_MAP_IM,
    OP_SQ_X,
    OP_SQ_Y,
    OP_SQ_XM,
    OP_SQ_X1,
    OP_CARD,
    OP_MXY,
    OP_SQ_NX,
    OP_SQ_NY
  } mbe_op_t;

  // Controller to datapath
  typedef struct packed {
    logic    load;
    logic    mul_go;
    logic    commit;
    mbe_op_t op;
    logic    step;
    logic    emit;
  } mbe_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic mul_done;
    logic run;
    logic out_free;
  } mbe_stat_t;

  // Saturating signed add
  function automatic logic [DATA_W-1:0] sat_add(input logic [DATA_W-1:0] a,
                                                input logic [DATA_W-1:0] b);
    logic [DATA_W-1:0] s;
    s = a + b;
    if ((a[DATA_W-1] == b[DATA_W-1]) && (s[DATA_W-1] != a[DATA_W-1])) begin
      return a[DATA_W-1] ? SMIN : SMAX;
    end
    return s;
  endfunction

  // Saturating signed subtract
  function automatic logic [DATA_W-1:0] sat_sub(input logic [DATA_W-1:0] a,
                                                input logic [DATA_W-1:0] b);
    logic [DATA_W-1:0] s;
    s = a - b;
    if ((a[DATA_W-1] != b[DATA_W-1]) && (s[DATA_W-1] != a[DATA_W-1])) begin
      return a[DATA_W-1] ? SMIN : SMAX;
    end
    return s;
  endfunction

  // Signed a <= b
  function automatic logic s_le(input logic [DATA_W-1:0] a,
                                input logic [DATA_W-1:0] b);
    return $signed(a) <= $signed(b);
  endfunction

endpackage

// ----- design/mbe_in_if.sv -----
// Pixel request channel: valid/ready handshake with column and row.
// Depends on mbe_pkg for field widths.
interface mbe_in_if;
  logic                         valid;
  logic                         ready;
  logic [mbe_pkg::COORD_W-1:0]  pixel_col;
  logic [mbe_pkg::COORD_W-1:0]  pixel_row;

  modport source(output valid, output pixel_col, output pixel_row, input ready);
  modport sink(input valid, input pixel_col, input pixel_row, output ready);
endinterface

// ----- design/mbe_out_if.sv -----
// Result channel: valid/ready handshake with iteration count and inside flag.
// Depends on mbe_pkg for field widths.
interface mbe_out_if;
  logic                         valid;
  logic                         ready;
  logic [mbe_pkg::COUNT_W-1:0]  iter_count;
  logic                         is_inside;

  modport source(output valid, output iter_count, output is_inside, input ready);
  modport sink(input valid, input iter_count, input is_inside, output ready);
endinterface

// ----- design/mbe_cfg.sv -----
// APB-style configuration register file, 64-bit registers at 8-byte stride.
// Depends on mbe_pkg for register indexes, reset values and the config struct.
module mbe_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [mbe_pkg::PADDR_W-1:0]     paddr,
  input  logic [mbe_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [mbe_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready,
  output mbe_pkg::mbe_cfg_t               cfg
);

  mbe_pkg::mbe_cfg_t cfg_r;
  mbe_pkg::mbe_reg_t idx;
  logic              wr_en;

  assign idx    = mbe_pkg::mbe_reg_t'(paddr[mbe_pkg::PADDR_W-1:3]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.center_re    <= '0;
      cfg_r.center_im    <= '0;
      cfg_r.pixel_step   <= mbe_pkg::RST_PIXEL_STEP;
      cfg_r.max_iter     <= mbe_pkg::RST_MAX_ITER;
      cfg_r.image_width  <= mbe_pkg::RST_IMAGE_DIM;
      cfg_r.image_height <= mbe_pkg::RST_IMAGE_DIM;
    end else if (wr_en) begin
      unique case (idx)
        mbe_pkg::REG_CENTER_RE:    cfg_r.center_re    <= pwdata;
        mbe_pkg::REG_CENTER_IM:    cfg_r.center_im    <= pwdata;
        mbe_pkg::REG_PIXEL_STEP:   cfg_r.pixel_step   <= pwdata[mbe_pkg::STEP_W-1:0];
        mbe_pkg::REG_MAX_ITER:     cfg_r.max_iter     <= pwdata[mbe_pkg::COUNT_W-1:0];
        mbe_pkg::REG_IMAGE_WIDTH:  cfg_r.image_width  <= pwdata[mbe_pkg::DIM_REG_W-1:0];
        mbe_pkg::REG_IMAGE_HEIGHT: cfg_r.image_height <= pwdata[mbe_pkg::DIM_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    unique case (idx)
      mbe_pkg::REG_CENTER_RE:    prdata = cfg_r.center_re;
      mbe_pkg::REG_CENTER_IM:    prdata = cfg_r.center_im;
      mbe_pkg::REG_PIXEL_STEP:   prdata = {1'b0, cfg_r.pixel_step};
      mbe_pkg::REG_MAX_ITER:     prdata = 64'(cfg_r.max_iter);
      mbe_pkg::REG_IMAGE_WIDTH:  prdata = 64'(cfg_r.image_width);
      mbe_pkg::REG_IMAGE_HEIGHT: prdata = 64'(cfg_r.image_height);
      default:                   prdata = '0;
    endcase
  end

endmodule

// ----- design/mbe_mul.sv -----
// Shared 64x64 signed multiplier: four 32x32 partial products, a sign fix
// for each operand, then floor shift and saturation. Uses mbe_pkg.
module mbe_mul (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        go,
  input  logic [mbe_pkg::DATA_W-1:0]  a,
  input  logic [mbe_pkg::DATA_W-1:0]  b,
  input  mbe_pkg::mbe_sh_t            sh,
  output logic                        done,
  output logic [mbe_pkg::DATA_W-1:0]  p
);

  typedef enum logic [2:0] {
    MP_IDLE,
    MP_PP0,
    MP_PP1,
    MP_PP2,
    MP_PP3,
    MP_FIXA,
    MP_FIXB,
    MP_OUT
  } mul_phase_t;

  mul_phase_t                  phase_r;
  logic [63:0]                 a_r;
  logic [63:0]                 b_r;
  mbe_pkg::mbe_sh_t            sh_r;
  logic [127:0]                acc_r;
  logic [63:0]                 p_r;
  logic                        done_r;
  logic [31:0]                 pa;
  logic [31:0]                 pb;
  logic [63:0]                 pp;
  logic [127:0]                pp_ext;
  logic [127:0]                sv;
  logic                        fits;
  logic [63:0]                 sat;

  // Partial product select
  assign pa = (phase_r == MP_PP2 || phase_r == MP_PP3) ? a_r[63:32] : a_r[31:0];
  assign pb = (phase_r == MP_PP1 || phase_r == MP_PP3) ? b_r[63:32] : b_r[31:0];
  assign pp = pa * pb;

  always_comb begin
    case (phase_r)
      MP_PP0:         pp_ext = {64'd0, pp};
      MP_PP1, MP_PP2: pp_ext = {32'd0, pp, 32'd0};
      MP_PP3:         pp_ext = {pp, 64'd0};
      default:        pp_ext = '0;
    endcase
  end

  // Floor shift of the signed 128-bit product, then saturate to 64 bits
  always_comb begin
    case (sh_r)
      mbe_pkg::SH_51: sv = $unsigned($signed(acc_r) >>> 51);
      mbe_pkg::SH_52: sv = $unsigned($signed(acc_r) >>> 52);
      default:        sv = acc_r;
    endcase
    fits = (&sv[127:63]) || !(|sv[127:63]);
    sat  = fits ? sv[63:0] : (acc_r[127] ? mbe_pkg::SMIN : mbe_pkg::SMAX);
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= MP_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= (phase_r == MP_OUT);
      unique case (phase_r)
        MP_IDLE: begin
          if (go) begin
            a_r     <= a;
            b_r     <= b;
            sh_r    <= sh;
            acc_r   <= '0;
            phase_r <= MP_PP0;
          end
        end
        MP_PP0: begin
          acc_r   <= acc_r + pp_ext;
          phase_r <= MP_PP1;
        end
        MP_PP1: begin
          acc_r   <= acc_r + pp_ext;
          phase_r <= MP_PP2;
        end
        MP_PP2: begin
          acc_r   <= acc_r + pp_ext;
          phase_r <= MP_PP3;
        end
        MP_PP3: begin
          acc_r   <= acc_r + pp_ext;
          phase_r <= MP_FIXA;
        end
        // unsigned to signed: subtract the other operand from the high half
        MP_FIXA: begin
          if (a_r[63]) begin
            acc_r[127:64] <= acc_r[127:64] - b_r;
          end
          phase_r <= MP_FIXB;
        end
        MP_FIXB: begin
          if (b_r[63]) begin
            acc_r[127:64] <= acc_r[127:64] - a_r;
          end
          phase_r <= MP_OUT;
        end
        MP_OUT: begin
          p_r     <= sat;
          phase_r <= MP_IDLE;
        end
        default: phase_r <= MP_IDLE;
      endcase
    end
  end

  assign done = done_r;
  assign p    = p_r;

endmodule

// ----- design/mbe_dp.sv -----
// Datapath: point mapping, bulb/cardioid test, z iteration registers,
// period check and result register. Uses mbe_pkg and mbe_mul.
module mbe_dp #(
  parameter int MAX_DIM      = mbe_pkg::MAX_DIM_DEF,
  parameter int PERIOD_CHECK = mbe_pkg::PERIOD_CHECK_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mbe_pkg::mbe_cfg_t             cfg,
  input  logic [mbe_pkg::COORD_W-1:0]   pixel_col,
  input  logic [mbe_pkg::COORD_W-1:0]   pixel_row,
  input  mbe_pkg::mbe_cmd_t             cmd,
  output mbe_pkg::mbe_stat_t            stat,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [mbe_pkg::COUNT_W-1:0]   iter_count,
  output logic                          is_inside
);

  localparam int DIM_W = $clog2(MAX_DIM + 1);
  localparam int CLW   = (DIM_W > mbe_pkg::DIM_REG_W) ? DIM_W : mbe_pkg::DIM_REG_W;
  localparam int PC_W  = $clog2(PERIOD_CHECK + 1);

  logic [mbe_pkg::COORD_W-1:0]  col_r;
  logic [mbe_pkg::COORD_W-1:0]  row_r;
  logic [63:0]                  cx_r;
  logic [63:0]                  cy_r;
  logic [63:0]                  x_r;
  logic [63:0]                  y_r;
  logic [63:0]                  x2_r;
  logic [63:0]                  y2_r;
  logic [63:0]                  xm_r;
  logic [63:0]                  q_r;
  logic [63:0]                  px_r;
  logic [63:0]                  py_r;
  logic                         bulb_r;
  logic [mbe_pkg::COUNT_W-1:0]  count_r;
  logic [PC_W-1:0]              pc_r;
  logic [PC_W-1:0]              pc_inc;
  logic                         out_valid_r;
  logic [mbe_pkg::COUNT_W-1:0]  iter_r;
  logic                         inside_r;

  logic [CLW-1:0]               w_ext;
  logic [CLW-1:0]               h_ext;
  logic [CLW-1:0]               w_cl;
  logic [CLW-1:0]               h_cl;
  logic [63:0]                  off_col;
  logic [63:0]                  off_row;
  logic [63:0]                  mul_a;
  logic [63:0]                  mul_b;
  mbe_pkg::mbe_sh_t             mul_sh;
  logic                         mul_done;
  logic [63:0]                  mul_p;
  logic                         out_free;

  // Pixel offset from image center, dimensions clamped to MAX_DIM
  assign w_ext   = CLW'(cfg.image_width);
  assign h_ext   = CLW'(cfg.image_height);
  assign w_cl    = (w_ext > CLW'(MAX_DIM)) ? CLW'(MAX_DIM) : w_ext;
  assign h_cl    = (h_ext > CLW'(MAX_DIM)) ? CLW'(MAX_DIM) : h_ext;
  assign off_col = 64'(col_r) - 64'(w_cl >> 1);
  assign off_row = 64'(row_r) - 64'(h_cl >> 1);

  // Multiplier operand select
  always_comb begin
    mul_a  = x_r;
    mul_b  = y_r;
    mul_sh = mbe_pkg::SH_52;
    case (cmd.op)
      mbe_pkg::OP_MAP_RE: begin
        mul_a  = off_col;
        mul_b  = {1'b0, cfg.pixel_step};
        mul_sh = mbe_pkg::SH_0;
      end
      mbe_pkg::OP_MAP_IM: begin
        mul_a  = off_row;
        mul_b  = {1'b0, cfg.pixel_step};
        mul_sh = mbe_pkg::SH_0;
      end
      mbe_pkg::OP_SQ_X, mbe_pkg::OP_SQ_NX: begin
        mul_a = x_r;
        mul_b = x_r;
      end
      mbe_pkg::OP_SQ_Y, mbe_pkg::OP_SQ_NY: begin
        mul_a = y_r;
        mul_b = y_r;
      end
      mbe_pkg::OP_SQ_XM: begin
        mul_a = xm_r;
        mul_b = xm_r;
      end
      mbe_pkg::OP_SQ_X1: begin
        mul_a = mbe_pkg::sat_add(x_r, mbe_pkg::QONE);
        mul_b = mbe_pkg::sat_add(x_r, mbe_pkg::QONE);
      end
      mbe_pkg::OP_CARD: begin
        mul_a = q_r;
        mul_b = mbe_pkg::sat_add(q_r, xm_r);
      end
      mbe_pkg::OP_MXY: begin
        mul_sh = mbe_pkg::SH_51;
      end
      default: ;
    endcase
  end

  mbe_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (cmd.mul_go),
    .a     (mul_a),
    .b     (mul_b),
    .sh    (mul_sh),
    .done  (mul_done),
    .p     (mul_p)
  );

  assign pc_inc = pc_r + PC_W'(1);

  // Working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      col_r   <= pixel_col;
      row_r   <= pixel_row;
      count_r <= mbe_pkg::COUNT_W'(1);
      pc_r    <= PC_W'(1);
    end
    if (cmd.commit) begin
      case (cmd.op)
        mbe_pkg::OP_MAP_RE: begin
          cx_r <= mbe_pkg::sat_add(cfg.center_re, mul_p);
          x_r  <= mbe_pkg::sat_add(cfg.center_re, mul_p);
          px_r <= mbe_pkg::sat_add(cfg.center_re, mul_p);
        end
        mbe_pkg::OP_MAP_IM: begin
          cy_r <= mbe_pkg::sat_add(cfg.center_im, mul_p);
          y_r  <= mbe_pkg::sat_add(cfg.center_im, mul_p);
          py_r <= mbe_pkg::sat_add(cfg.center_im, mul_p);
        end
        mbe_pkg::OP_SQ_X: begin
          x2_r <= mul_p;
          xm_r <= mbe_pkg::sat_sub(x_r, mbe_pkg::QQUARTER);
        end
        mbe_pkg::OP_SQ_Y, mbe_pkg::OP_SQ_NY: y2_r <= mul_p;
        mbe_pkg::OP_SQ_NX: x2_r <= mul_p;
        mbe_pkg::OP_SQ_XM: q_r <= mbe_pkg::sat_add(mul_p, y2_r);
        mbe_pkg::OP_SQ_X1: begin
          bulb_r <= mbe_pkg::s_le(mbe_pkg::sat_add(mul_p, y2_r), mbe_pkg::QSIXTEENTH);
        end
        // inside the bulb or cardioid: jump straight to the limit
        mbe_pkg::OP_CARD: begin
          if (bulb_r || mbe_pkg::s_le(mul_p, {2'b00, y2_r[63:2]})) begin
            count_r <= cfg.max_iter;
          end
        end
        mbe_pkg::OP_MXY: begin
          x_r <= mbe_pkg::sat_add(mbe_pkg::sat_sub(x2_r, y2_r), cx_r);
          y_r <= mbe_pkg::sat_add(mul_p, cy_r);
        end
        default: ;
      endcase
    end
    // count advance and periodic exact-cycle check
    if (cmd.step) begin
      if (pc_inc >= PC_W'(PERIOD_CHECK)) begin
        pc_r <= '0;
        if (px_r == x_r && py_r == y_r) begin
          count_r <= cfg.max_iter;
        end else begin
          count_r <= count_r + mbe_pkg::COUNT_W'(1);
          px_r    <= x_r;
          py_r    <= y_r;
        end
      end else begin
        pc_r    <= pc_inc;
        count_r <= count_r + mbe_pkg::COUNT_W'(1);
      end
    end
    if (cmd.emit) begin
      iter_r   <= count_r;
      inside_r <= (count_r == cfg.max_iter);
    end
  end

  // Result register valid
  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Status back to the controller
  assign stat.mul_done = mul_done;
  assign stat.run      = (count_r < cfg.max_iter) &&
                         mbe_pkg::s_le(mbe_pkg::sat_add(x2_r, y2_r), mbe_pkg::QESCAPE);
  assign stat.out_free = out_free;

  assign out_valid  = out_valid_r;
  assign iter_count = iter_r;
  assign is_inside  = inside_r;

endmodule

// ----- design/mbe_ctrl.sv -----
// Controller: sequences the multiplier operations for setup and each
// iteration, and hands the result to the output register. Uses mbe_pkg.
module mbe_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  mbe_pkg::mbe_stat_t  stat,
  output mbe_pkg::mbe_cmd_t   cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_MAP_RE,
    S_MAP_IM,
    S_SQ_X,
    S_SQ_Y,
    S_SQ_XM,
    S_SQ_X1,
    S_CARD,
    S_TEST,
    S_MXY,
    S_SQ_NX,
    S_SQ_NY,
    S_STEP,
    S_FINISH
  } ctrl_state_t;

  ctrl_state_t state_r;
  ctrl_state_t state_nxt;
  logic        go_r;
  logic        go_nxt;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    go_nxt    = 1'b0;
    in_ready  = 1'b0;
    cmd       = '0;
    cmd.op    = mbe_pkg::OP_NONE;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_MAP_RE;
          go_nxt    = 1'b1;
        end
      end
      S_MAP_RE: begin
        cmd.op = mbe_pkg::OP_MAP_RE;
        if (stat.mul_done) begin
          state_nxt = S_MAP_IM;
          go_nxt    = 1'b1;
        end
      end
      S_MAP_IM: begin
        cmd.op = mbe_pkg::OP_MAP_IM;
        if (stat.mul_done) begin
          state_nxt = S_SQ_X;
          go_nxt    = 1'b1;
        end
      end
      S_SQ_X: begin
        cmd.op = mbe_pkg::OP_SQ_X;
        if (stat.mul_done) begin
          state_nxt = S_SQ_Y;
          go_nxt    = 1'b1;
        end
      end
      S_SQ_Y: begin
        cmd.op = mbe_pkg::OP_SQ_Y;
        if (stat.mul_done) begin
          state_nxt = S_SQ_XM;
          go_nxt    = 1'b1;
        end
      end
      S_SQ_XM: begin
        cmd.op = mbe_pkg::OP_SQ_XM;
        if (stat.mul_done) begin
          state_nxt = S_SQ_X1;
          go_nxt    = 1'b1;
        end
      end
      S_SQ_X1: begin
        cmd.op = mbe_pkg::OP_SQ_X1;
        if (stat.mul_done) begin
          state_nxt = S_CARD;
          go_nxt    = 1'b1;
        end
      end
      S_CARD: begin
        cmd.op = mbe_pkg::OP_CARD;
        if (stat.mul_done) begin
          state_nxt = S_TEST;
        end
      end
      // loop condition: below the limit and not escaped
      S_TEST: begin
        if (stat.run) begin
          state_nxt = S_MXY;
          go_nxt    = 1'b1;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_MXY: begin
        cmd.op = mbe_pkg::OP_MXY;
        if (stat.mul_done) begin
          state_nxt = S_SQ_NX;
          go_nxt    = 1'b1;
        end
      end
      S_SQ_NX: begin
        cmd.op = mbe_pkg::OP_SQ_NX;
        if (stat.mul_done) begin
          state_nxt = S_SQ_NY;
          go_nxt    = 1'b1;
        end
      end
      S_SQ_NY: begin
        cmd.op = mbe_pkg::OP_SQ_NY;
        if (stat.mul_done) begin
          state_nxt = S_STEP;
        end
      end
      S_STEP: begin
        cmd.step  = 1'b1;
        state_nxt = S_TEST;
      end
      // wait until the result register is free
      S_FINISH: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    cmd.mul_go = go_r;
    cmd.commit = stat.mul_done;
  end

  // State and registered start pulse
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      go_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      go_r    <= go_nxt;
    end
  end

endmodule

// ----- design/mandelbrot_escape_time_top.sv -----
// Mandelbrot escape-time evaluator, one pixel request at a time.
// Depends on mbe_pkg, mbe_in_if, mbe_out_if, mbe_cfg, mbe_ctrl, mbe_dp.
//
// Usage:
//   in_chan takes one pixel request (pixel_col, pixel_row) when valid and
//   ready are both high; ready is high only while no pixel is in work.
//   out_chan returns one result per request (iter_count, is_inside) from an
//   output register; the next request is taken while that result waits.
//   The APB port (psel/penable/pwrite/paddr/pwdata) sets the six 64-bit
//   registers at byte address 8*index; write them only while idle.
// Sequencing:
//   All products go through one shared 64x64 multiplier; each product holds
//   the controller through its start, four 32x32 partial products, a sign
//   fix for each operand and the shift/saturate step. Setup takes 7
//   products; each further iteration takes 3 products plus the S_STEP and
//   S_TEST control states. The next request can be taken in the same cycle
//   that a result shows.
// Reset (rst_n low, synchronous) clears the control state and restores the
// register defaults. A stalled result holds out_chan until it is taken;
// the block then waits with a finished pixel but stays ready before that.
module mandelbrot_escape_time_top #(
  parameter int MAX_DIM      = mbe_pkg::MAX_DIM_DEF,
  parameter int PERIOD_CHECK = mbe_pkg::PERIOD_CHECK_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  mbe_in_if.sink                          in_chan,
  mbe_out_if.source                       out_chan,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [mbe_pkg::PADDR_W-1:0]     paddr,
  input  logic [mbe_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [mbe_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready
);

  mbe_pkg::mbe_cfg_t   cfg;
  mbe_pkg::mbe_cmd_t   cmd;
  mbe_pkg::mbe_stat_t  stat;
  logic                in_ready;
  logic                out_valid;
  logic [mbe_pkg::COUNT_W-1:0] iter_count;
  logic                is_inside;

  mbe_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mbe_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  mbe_dp #(
    .MAX_DIM      (MAX_DIM),
    .PERIOD_CHECK (PERIOD_CHECK)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .pixel_col  (in_chan.pixel_col),
    .pixel_row  (in_chan.pixel_row),
    .cmd        (cmd),
    .stat       (stat),
    .out_ready  (out_chan.ready),
    .out_valid  (out_valid),
    .iter_count (iter_count),
    .is_inside  (is_inside)
  );

  assign in_chan.ready       = in_ready;
  assign out_chan.valid      = out_valid;
  assign out_chan.iter_count = iter_count;
  assign out_chan.is_inside  = is_inside;

endmodule

// ----- design/mbe_chk.sv -----
// Port-level checker for the escape-time block, bound to the top level.
// Depends on mbe_pkg and the assertion macro header.
`include "mandelbrot_escape_time_top_macros.svh"

module mbe_chk (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [mbe_pkg::COUNT_W-1:0]    iter_count,
  input logic                           is_inside
);

  // stalled result stays offered
  `MBE_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)

  // stalled result keeps its payload
  `MBE_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready,
                   $stable(iter_count) && $stable(is_inside))

  // one pixel at a time: a taken request closes the input
  `MBE_ASSERT_NEXT(a_busy_after_req, clk, rst_n, in_valid && in_ready, !in_ready)

  // an escaped point reports a nonzero iteration count
  `MBE_ASSERT_NOW(a_escape_count, clk, rst_n, out_valid && !is_inside,
                  iter_count != '0)

endmodule

bind mandelbrot_escape_time_top mbe_chk u_mbe_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_chan.valid),
  .in_ready   (in_chan.ready),
  .out_valid  (out_chan.valid),
  .out_ready  (out_chan.ready),
  .iter_count (out_chan.iter_count),
  .is_inside  (out_chan.is_inside)
);
